[hdl/rmq_pkg.sv]
// Shared constants for the rotation matrix to quaternion pipeline.
package rmq_pkg;

	localparam int IN_W  = 16;
	localparam int OUT_W = 16;
	localparam int NQ    = 4;

	// Quaternion lane codes.
	localparam int QW = 0;
	localparam int QX = 1;
	localparam int QY = 2;
	localparam int QZ = 3;

	localparam int OUT_MAX = 32767;
	localparam int OUT_MIN = -32768;

endpackage

[hdl/rmq_front.sv]
// Input saturation, diagonal magnitudes, largest-lane choice and sign selection.
module rmq_front #(
	parameter int FRAC_BITS = 14,
	parameter int RAD_W = 2 * FRAC_BITS + 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic v_in,
	input  logic [8:0][rmq_pkg::IN_W-1:0] m_in,
	output logic v_s1,
	output logic [rmq_pkg::NQ-1:0][RAD_W-1:0] rad_s1,
	output logic [rmq_pkg::NQ-1:0] neg_s1
);

	localparam int EW = FRAC_BITS + 2;
	localparam int SW = FRAC_BITS + 4;
	localparam int CW = FRAC_BITS + 3;
	localparam logic signed [31:0] ONE32 = 32'sd1 <<< FRAC_BITS;

	function automatic logic signed [EW-1:0] sat_elem(input logic [rmq_pkg::IN_W-1:0] raw);
		logic signed [31:0] v;
		v = 32'(signed'(raw));
		if (v > ONE32) v = ONE32;
		if (v < -ONE32) v = -ONE32;
		return v[EW-1:0];
	endfunction

	logic signed [SW-1:0] x [9];
	logic signed [SW-1:0] one_s;
	logic signed [SW-1:0] s [4];
	logic [CW-1:0] cs [4];
	logic signed [SW-1:0] d_a, d_b, d_c, d_d, d_e, d_g;
	logic [1:0] big;
	logic [rmq_pkg::NQ-1:0] neg;
	logic [rmq_pkg::NQ-1:0][RAD_W-1:0] rad;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			x[i] = SW'(sat_elem(m_in[i]));
		end
		one_s = SW'(ONE32);
		s[0] = one_s + x[0] + x[4] + x[8];
		s[1] = one_s + x[0] - x[4] - x[8];
		s[2] = one_s - x[0] + x[4] - x[8];
		s[3] = one_s - x[0] - x[4] + x[8];
		for (int i = 0; i < 4; i++) begin
			cs[i] = s[i][SW-1] ? '0 : s[i][CW-1:0];
			rad[i] = RAD_W'(cs[i]) << FRAC_BITS;
		end
		d_a = x[7] - x[5];
		d_b = x[2] - x[6];
		d_c = x[3] - x[1];
		d_d = x[3] + x[1];
		d_e = x[2] + x[6];
		d_g = x[7] + x[5];
		if (cs[0] >= cs[1] && cs[0] >= cs[2] && cs[0] >= cs[3]) begin
			big = 2'(rmq_pkg::QW);
		end else if (cs[1] >= cs[2] && cs[1] >= cs[3]) begin
			big = 2'(rmq_pkg::QX);
		end else if (cs[2] >= cs[3]) begin
			big = 2'(rmq_pkg::QY);
		end else begin
			big = 2'(rmq_pkg::QZ);
		end
		neg = '0;
		case (big)
			2'(rmq_pkg::QW): begin
				neg[rmq_pkg::QX] = d_a[SW-1];
				neg[rmq_pkg::QY] = d_b[SW-1];
				neg[rmq_pkg::QZ] = d_c[SW-1];
			end
			2'(rmq_pkg::QX): begin
				neg[rmq_pkg::QW] = d_a[SW-1];
				neg[rmq_pkg::QY] = d_d[SW-1];
				neg[rmq_pkg::QZ] = d_e[SW-1];
			end
			2'(rmq_pkg::QY): begin
				neg[rmq_pkg::QW] = d_b[SW-1];
				neg[rmq_pkg::QX] = d_d[SW-1];
				neg[rmq_pkg::QZ] = d_g[SW-1];
			end
			default: begin
				neg[rmq_pkg::QW] = d_c[SW-1];
				neg[rmq_pkg::QX] = d_e[SW-1];
				neg[rmq_pkg::QY] = d_g[SW-1];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		rad_s1 <= rad;
		neg_s1 <= neg;
	end

endmodule

[hdl/rmq_sqrt_cell.sv]
// One cell of the square root chain: settles one root bit per lane.
module rmq_sqrt_cell #(
	parameter int LANES = 4,
	parameter int ROOT_W = 16,
	parameter int J = 0,
	parameter int SIDE_W = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic v_in,
	input  logic [LANES-1:0][2*ROOT_W-1:0] rad_in,
	input  logic [LANES-1:0][ROOT_W+1:0] rem_in,
	input  logic [LANES-1:0][ROOT_W-1:0] root_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic v_s1,
	output logic [LANES-1:0][2*ROOT_W-1:0] rad_s1,
	output logic [LANES-1:0][ROOT_W+1:0] rem_s1,
	output logic [LANES-1:0][ROOT_W-1:0] root_s1,
	output logic [SIDE_W-1:0] side_s1
);

	logic [LANES-1:0][ROOT_W+3:0] cur;
	logic [LANES-1:0][ROOT_W+3:0] trial;
	logic [LANES-1:0][ROOT_W+3:0] diff;
	logic [LANES-1:0] ge;
	logic [LANES-1:0][ROOT_W+1:0] rem_n;
	logic [LANES-1:0][ROOT_W-1:0] root_n;

	// Bring down the next radicand bit pair and try root*4+1 against it.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			cur[l] = {rem_in[l], rad_in[l][2*J+1 -: 2]};
			trial[l] = (ROOT_W+4)'({root_in[l], 2'b01});
			ge[l] = cur[l] >= trial[l];
			diff[l] = cur[l] - trial[l];
			rem_n[l] = ge[l] ? diff[l][ROOT_W+1:0] : cur[l][ROOT_W+1:0];
			root_n[l] = {root_in[l][ROOT_W-2:0], ge[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		rad_s1 <= rad_in;
		rem_s1 <= rem_n;
		root_s1 <= root_n;
		side_s1 <= side_in;
	end

endmodule

[hdl/rmq_norm.sv]
// Squares of the four magnitudes and their sum, two registered steps.
module rmq_norm #(
	parameter int A_W = 16,
	parameter int SIDE_W = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic v_in,
	input  logic [rmq_pkg::NQ-1:0][A_W-1:0] a_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic v_s2,
	output logic [2*A_W+1:0] sum_s2,
	output logic [SIDE_W-1:0] side_s2
);

	logic v_s1;
	logic [rmq_pkg::NQ-1:0][2*A_W-1:0] sq_s1;
	logic [SIDE_W-1:0] side_s1;
	logic [2*A_W+1:0] sum;

	always_comb begin
		sum = '0;
		for (int l = 0; l < rmq_pkg::NQ; l++) begin
			sum = sum + (2*A_W+2)'(sq_s1[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < rmq_pkg::NQ; l++) begin
			sq_s1[l] <= a_in[l] * a_in[l];
		end
		side_s1 <= side_in;
		sum_s2 <= sum;
		side_s2 <= side_s1;
	end

endmodule

[hdl/rmq_div_cell.sv]
// One cell of the divider chain: settles one quotient bit per lane.
module rmq_div_cell #(
	parameter int LANES = 4,
	parameter int REM_W = 32,
	parameter int DEN_W = 16,
	parameter int QUO_W = 15,
	parameter int K = 0,
	parameter int SIDE_W = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic v_in,
	input  logic [DEN_W-1:0] den_in,
	input  logic [LANES-1:0][REM_W-1:0] rem_in,
	input  logic [LANES-1:0][QUO_W-1:0] quo_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic v_s1,
	output logic [DEN_W-1:0] den_s1,
	output logic [LANES-1:0][REM_W-1:0] rem_s1,
	output logic [LANES-1:0][QUO_W-1:0] quo_s1,
	output logic [SIDE_W-1:0] side_s1
);

	logic [REM_W-1:0] t;
	logic [LANES-1:0][REM_W-1:0] rem_n;
	logic [LANES-1:0][QUO_W-1:0] quo_n;

	always_comb begin
		t = REM_W'(den_in) << K;
		for (int l = 0; l < LANES; l++) begin
			quo_n[l] = quo_in[l];
			if (rem_in[l] >= t) begin
				rem_n[l] = rem_in[l] - t;
				quo_n[l][K] = 1'b1;
			end else begin
				rem_n[l] = rem_in[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		den_s1 <= den_in;
		rem_s1 <= rem_n;
		quo_s1 <= quo_n;
		side_s1 <= side_in;
	end

endmodule

[hdl/rotation_matrix_to_quaternion.sv]
// Top level: rotation matrix to unit quaternion, a chain of bit cells.
//
//   Channel   Direction  Handshake            Payload
//   matrix    in         start (busy is low)  m00 m01 m02 m10 m11 m12 m20 m21 m22
//   quat      out        done, one cycle      quat_x quat_y quat_z quat_w
//
// A new matrix may be started in every cycle; busy is always low. Each
// transaction passes through one front register, FRAC_BITS+2 root cells, two
// registered steps of squaring and summing, FRAC_BITS+3 root cells for the
// norm, one set-up register, FRAC_BITS+1 divider cells and one output
// register. The length is set by the three bit-serial cell rows. Reset
// clears only the valid chain. The receiver cannot stall, so done is a
// one-cycle strobe.
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [rmq_pkg::IN_W-1:0] m00,
	input  logic [rmq_pkg::IN_W-1:0] m01,
	input  logic [rmq_pkg::IN_W-1:0] m02,
	input  logic [rmq_pkg::IN_W-1:0] m10,
	input  logic [rmq_pkg::IN_W-1:0] m11,
	input  logic [rmq_pkg::IN_W-1:0] m12,
	input  logic [rmq_pkg::IN_W-1:0] m20,
	input  logic [rmq_pkg::IN_W-1:0] m21,
	input  logic [rmq_pkg::IN_W-1:0] m22,
	output logic done,
	output logic [rmq_pkg::OUT_W-1:0] quat_x,
	output logic [rmq_pkg::OUT_W-1:0] quat_y,
	output logic [rmq_pkg::OUT_W-1:0] quat_z,
	output logic [rmq_pkg::OUT_W-1:0] quat_w
);

	localparam int NQ = rmq_pkg::NQ;
	// First root: sqrt(s << FRAC_BITS), with s at most 4.0.
	localparam int N1 = FRAC_BITS + 2;
	// Norm root: sqrt of the sum of four squares of N1-bit values.
	localparam int N2 = FRAC_BITS + 3;
	localparam int SIDE2_W = NQ * N1 + NQ;
	localparam int DEN_W = N2 + 1;
	localparam int REM_W = 2 * FRAC_BITS + 6;
	localparam int QB = FRAC_BITS + 1;
	localparam int DSIDE_W = NQ + 1;

	// No stage ever holds back, so the block never refuses a transaction.
	assign busy = 1'b0;

	// Front stage.
	logic f_v;
	logic [NQ-1:0][2*N1-1:0] f_rad;
	logic [NQ-1:0] f_neg;

	rmq_front #(.FRAC_BITS(FRAC_BITS), .RAD_W(2 * N1)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.v_in(start),
		.m_in({m22, m21, m20, m12, m11, m10, m02, m01, m00}),
		.v_s1(f_v),
		.rad_s1(f_rad),
		.neg_s1(f_neg)
	);

	// Magnitude roots, four lanes side by side, one bit per cell.
	logic [N1:0] r1_v;
	logic [N1:0][NQ-1:0][2*N1-1:0] r1_rad;
	logic [N1:0][NQ-1:0][N1+1:0] r1_rem;
	logic [N1:0][NQ-1:0][N1-1:0] r1_root;
	logic [N1:0][NQ-1:0] r1_side;

	assign r1_v[0] = f_v;
	assign r1_rad[0] = f_rad;
	assign r1_rem[0] = '0;
	assign r1_root[0] = '0;
	assign r1_side[0] = f_neg;

	for (genvar c = 0; c < N1; c++) begin : g_root1
		rmq_sqrt_cell #(.LANES(NQ), .ROOT_W(N1), .J(N1 - 1 - c), .SIDE_W(NQ)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.v_in(r1_v[c]),
			.rad_in(r1_rad[c]),
			.rem_in(r1_rem[c]),
			.root_in(r1_root[c]),
			.side_in(r1_side[c]),
			.v_s1(r1_v[c+1]),
			.rad_s1(r1_rad[c+1]),
			.rem_s1(r1_rem[c+1]),
			.root_s1(r1_root[c+1]),
			.side_s1(r1_side[c+1])
		);
	end

	// Sum of squares; the magnitudes and signs ride along as side data.
	logic n_v;
	logic [2*N2-1:0] n_sum;
	logic [SIDE2_W-1:0] n_side;

	rmq_norm #(.A_W(N1), .SIDE_W(SIDE2_W)) u_norm (
		.clk(clk),
		.arst_n(arst_n),
		.v_in(r1_v[N1]),
		.a_in(r1_root[N1]),
		.side_in({r1_side[N1], r1_root[N1]}),
		.v_s2(n_v),
		.sum_s2(n_sum),
		.side_s2(n_side)
	);

	// Norm root, a single lane.
	logic [N2:0] r2_v;
	logic [N2:0][0:0][2*N2-1:0] r2_rad;
	logic [N2:0][0:0][N2+1:0] r2_rem;
	logic [N2:0][0:0][N2-1:0] r2_root;
	logic [N2:0][SIDE2_W-1:0] r2_side;

	assign r2_v[0] = n_v;
	assign r2_rad[0] = n_sum;
	assign r2_rem[0] = '0;
	assign r2_root[0] = '0;
	assign r2_side[0] = n_side;

	for (genvar c = 0; c < N2; c++) begin : g_root2
		rmq_sqrt_cell #(.LANES(1), .ROOT_W(N2), .J(N2 - 1 - c), .SIDE_W(SIDE2_W)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.v_in(r2_v[c]),
			.rad_in(r2_rad[c]),
			.rem_in(r2_rem[c]),
			.root_in(r2_root[c]),
			.side_in(r2_side[c]),
			.v_s1(r2_v[c+1]),
			.rad_s1(r2_rad[c+1]),
			.rem_s1(r2_rem[c+1]),
			.root_s1(r2_root[c+1]),
			.side_s1(r2_side[c+1])
		);
	end

	// Divider set-up: the numerator 2*a*one + norm over the denominator
	// 2*norm gives the quotient rounded to nearest, halves up.
	logic [N2-1:0] norm;
	logic [NQ-1:0][N1-1:0] a_mag;
	logic [NQ-1:0] a_neg;
	logic p_v_s4;
	logic [DEN_W-1:0] den_s4;
	logic [NQ-1:0][REM_W-1:0] num_s4;
	logic [DSIDE_W-1:0] dside_s4;

	assign norm = r2_root[N2][0];
	assign a_mag = r2_side[N2][NQ*N1-1:0];
	assign a_neg = r2_side[N2][SIDE2_W-1:NQ*N1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_v_s4 <= 1'b0;
		end else begin
			p_v_s4 <= r2_v[N2];
		end
	end

	always_ff @(posedge clk) begin
		den_s4 <= {norm, 1'b0};
		for (int l = 0; l < NQ; l++) begin
			num_s4[l] <= (REM_W'(a_mag[l]) << (FRAC_BITS + 1)) + REM_W'(norm);
		end
		// A zero norm cannot arise from a real matrix; it forces zero outputs.
		dside_s4 <= {(norm == '0), a_neg};
	end

	// Divider chain, one quotient bit per cell, four lanes.
	logic [QB:0] d_v;
	logic [QB:0][DEN_W-1:0] d_den;
	logic [QB:0][NQ-1:0][REM_W-1:0] d_rem;
	logic [QB:0][NQ-1:0][QB-1:0] d_quo;
	logic [QB:0][DSIDE_W-1:0] d_side;

	assign d_v[0] = p_v_s4;
	assign d_den[0] = den_s4;
	assign d_rem[0] = num_s4;
	assign d_quo[0] = '0;
	assign d_side[0] = dside_s4;

	for (genvar c = 0; c < QB; c++) begin : g_div
		rmq_div_cell #(
			.LANES(NQ),
			.REM_W(REM_W),
			.DEN_W(DEN_W),
			.QUO_W(QB),
			.K(QB - 1 - c),
			.SIDE_W(DSIDE_W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.v_in(d_v[c]),
			.den_in(d_den[c]),
			.rem_in(d_rem[c]),
			.quo_in(d_quo[c]),
			.side_in(d_side[c]),
			.v_s1(d_v[c+1]),
			.den_s1(d_den[c+1]),
			.rem_s1(d_rem[c+1]),
			.quo_s1(d_quo[c+1]),
			.side_s1(d_side[c+1])
		);
	end

	// Output stage: apply sign after rounding, then saturate to 16 bits.
	logic [NQ-1:0][rmq_pkg::OUT_W-1:0] qo;
	logic signed [33:0] qv;
	logic zero_norm;
	logic [NQ-1:0][rmq_pkg::OUT_W-1:0] q_s5;
	logic done_s5;

	assign zero_norm = d_side[QB][NQ];

	always_comb begin
		qv = '0;
		for (int l = 0; l < NQ; l++) begin
			qv = zero_norm ? 34'sd0 : signed'(34'(d_quo[QB][l]));
			if (d_side[QB][l]) begin
				qv = -qv;
			end
			if (qv > 34'(rmq_pkg::OUT_MAX)) begin
				qo[l] = rmq_pkg::OUT_W'(rmq_pkg::OUT_MAX);
			end else if (qv < 34'(rmq_pkg::OUT_MIN)) begin
				qo[l] = rmq_pkg::OUT_W'(rmq_pkg::OUT_MIN);
			end else begin
				qo[l] = qv[rmq_pkg::OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s5 <= 1'b0;
		end else begin
			done_s5 <= d_v[QB];
		end
	end

	always_ff @(posedge clk) begin
		q_s5 <= qo;
	end

	assign done = done_s5;
	assign quat_x = q_s5[rmq_pkg::QX];
	assign quat_y = q_s5[rmq_pkg::QY];
	assign quat_z = q_s5[rmq_pkg::QZ];
	assign quat_w = q_s5[rmq_pkg::QW];

endmodule

[bench/rotation_matrix_to_quaternion_tb.sv]
// Self-checking testbench for the rotation matrix to unit quaternion pipeline.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;

	localparam int FRAC_BITS = 14;
	localparam int ONE       = 1 << FRAC_BITS;
	// Pipeline depth from start to done.
	localparam int LATENCY   = FRAC_BITS * 3 + 11;
	localparam int N_RANDOM  = 1450;
	localparam int CYCLE_CAP = 400000;

	typedef logic signed [rmq_pkg::IN_W-1:0]  elem_t;
	typedef logic signed [rmq_pkg::OUT_W-1:0] comp_t;

	// One transaction on the matrix channel and one on the quaternion channel.
	typedef struct {
		elem_t m [9];
	} matrix_t;

	typedef struct packed {
		comp_t x;
		comp_t y;
		comp_t z;
		comp_t w;
	} quat_t;

	// A directed row: the matrix and, where it is obvious, the quaternion
	// that must come out of it.
	typedef struct {
		matrix_t mat;
		bit      has_known;
		quat_t   known;
	} row_t;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic  done;
	comp_t quat_x, quat_y, quat_z, quat_w;

	quat_t pending_quats [$];
	int    fail_count;
	longint cycle_count;

	rotation_matrix_to_quaternion #(
		.FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.m00(m00), .m01(m01), .m02(m02),
		.m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22),
		.done(done),
		.quat_x(quat_x),
		.quat_y(quat_y),
		.quat_z(quat_z),
		.quat_w(quat_w)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Bit-by-bit integer square root, floor of the true root.
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v    -= root + bitv;
				root  = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic longint clamp_elem(input elem_t e);
		longint v;
		v = e;
		if (v > ONE)
			v = ONE;
		if (v < -ONE)
			v = -ONE;
		return v;
	endfunction

	function automatic comp_t sat_comp(input longint v);
		if (v > rmq_pkg::OUT_MAX)
			v = rmq_pkg::OUT_MAX;
		if (v < rmq_pkg::OUT_MIN)
			v = rmq_pkg::OUT_MIN;
		return comp_t'(v);
	endfunction

	// A zero difference or sum counts as positive.
	function automatic bit is_neg(input longint v);
		return v < 0;
	endfunction

	// Expected unit quaternion for one matrix.
	function automatic quat_t quat_of_matrix(input matrix_t mat);
		longint          r [9];
		longint          mag2 [rmq_pkg::NQ];
		longint unsigned root [rmq_pkg::NQ];
		bit              neg [rmq_pkg::NQ];
		longint unsigned sumsq;
		longint unsigned norm;
		longint          comp [rmq_pkg::NQ];
		int              lead;
		quat_t           q;
		sumsq = 0;
		for (int i = 0; i < 9; i++)
			r[i] = clamp_elem(mat.m[i]);
		mag2[rmq_pkg::QW] = ONE + r[0] + r[4] + r[8];
		mag2[rmq_pkg::QX] = ONE + r[0] - r[4] - r[8];
		mag2[rmq_pkg::QY] = ONE - r[0] + r[4] - r[8];
		mag2[rmq_pkg::QZ] = ONE - r[0] - r[4] + r[8];
		for (int i = 0; i < rmq_pkg::NQ; i++) begin
			if (mag2[i] < 0)
				mag2[i] = 0;
			root[i] = int_sqrt(longint'(mag2[i]) << FRAC_BITS);
			sumsq  += root[i] * root[i];
		end
		// Ties go to the lowest lane in the order w, x, y, z.
		if (mag2[rmq_pkg::QW] >= mag2[rmq_pkg::QX] && mag2[rmq_pkg::QW] >= mag2[rmq_pkg::QY]
			&& mag2[rmq_pkg::QW] >= mag2[rmq_pkg::QZ])
			lead = rmq_pkg::QW;
		else if (mag2[rmq_pkg::QX] >= mag2[rmq_pkg::QY]
			&& mag2[rmq_pkg::QX] >= mag2[rmq_pkg::QZ])
			lead = rmq_pkg::QX;
		else if (mag2[rmq_pkg::QY] >= mag2[rmq_pkg::QZ])
			lead = rmq_pkg::QY;
		else
			lead = rmq_pkg::QZ;
		neg[lead] = 1'b0;
		case (lead)
			rmq_pkg::QW: begin
				neg[rmq_pkg::QX] = is_neg(r[7] - r[5]);
				neg[rmq_pkg::QY] = is_neg(r[2] - r[6]);
				neg[rmq_pkg::QZ] = is_neg(r[3] - r[1]);
			end
			rmq_pkg::QX: begin
				neg[rmq_pkg::QW] = is_neg(r[7] - r[5]);
				neg[rmq_pkg::QY] = is_neg(r[3] + r[1]);
				neg[rmq_pkg::QZ] = is_neg(r[2] + r[6]);
			end
			rmq_pkg::QY: begin
				neg[rmq_pkg::QW] = is_neg(r[2] - r[6]);
				neg[rmq_pkg::QX] = is_neg(r[3] + r[1]);
				neg[rmq_pkg::QZ] = is_neg(r[7] + r[5]);
			end
			default: begin
				neg[rmq_pkg::QW] = is_neg(r[3] - r[1]);
				neg[rmq_pkg::QX] = is_neg(r[6] + r[2]);
				neg[rmq_pkg::QY] = is_neg(r[7] + r[5]);
			end
		endcase
		norm = int_sqrt(sumsq);
		for (int i = 0; i < rmq_pkg::NQ; i++) begin
			comp[i] = 0;
			// Round half up in magnitude; the sign goes on afterwards.
			if (norm != 0)
				comp[i] = longint'((2 * root[i] * ONE + norm) / (2 * norm));
			if (neg[i])
				comp[i] = -comp[i];
		end
		q.x = sat_comp(comp[rmq_pkg::QX]);
		q.y = sat_comp(comp[rmq_pkg::QY]);
		q.z = sat_comp(comp[rmq_pkg::QZ]);
		q.w = sat_comp(comp[rmq_pkg::QW]);
		return q;
	endfunction

	function automatic matrix_t make_matrix(input int a0, a1, a2, a3, a4, a5, a6, a7, a8);
		matrix_t mat;
		mat.m[0] = elem_t'(a0); mat.m[1] = elem_t'(a1); mat.m[2] = elem_t'(a2);
		mat.m[3] = elem_t'(a3); mat.m[4] = elem_t'(a4); mat.m[5] = elem_t'(a5);
		mat.m[6] = elem_t'(a6); mat.m[7] = elem_t'(a7); mat.m[8] = elem_t'(a8);
		return mat;
	endfunction

	function automatic quat_t make_quat(input int x, y, z, w);
		quat_t q;
		q.x = comp_t'(x);
		q.y = comp_t'(y);
		q.z = comp_t'(z);
		q.w = comp_t'(w);
		return q;
	endfunction

	// Random element: mostly inside the legal range, sometimes any 16-bit value
	// so that every bit toggles and saturation is hit.
	function automatic elem_t rand_elem();
		case ($urandom_range(0, 9))
			0:       return elem_t'($urandom);
			1:       return ($urandom_range(0, 1) != 0) ? elem_t'(ONE) : elem_t'(-ONE);
			2:       return elem_t'(0);
			default: return elem_t'(int'($urandom_range(0, 2 * ONE)) - ONE);
		endcase
	endfunction

	// Random proper rotation from a random signed permutation with det +1,
	// perturbed a little so the leading lane and the signs are exercised.
	function automatic matrix_t rand_rotation();
		matrix_t mat;
		int      perm [3];
		int      sgn [3];
		int      tmp;
		int      j;
		int      parity;
		perm = '{0, 1, 2};
		parity = 0;
		for (int i = 2; i > 0; i--) begin
			j = $urandom_range(0, i);
			if (j != i) begin
				tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
				parity ^= 1;
			end
		end
		for (int i = 0; i < 3; i++)
			sgn[i] = ($urandom_range(0, 1) != 0) ? -1 : 1;
		// Force det = +1 by fixing the last sign.
		if ((parity != 0) ^ ((sgn[0] * sgn[1] * sgn[2]) < 0))
			sgn[2] = -sgn[2];
		for (int i = 0; i < 9; i++)
			mat.m[i] = elem_t'(0);
		for (int i = 0; i < 3; i++)
			mat.m[i * 3 + perm[i]] = elem_t'(sgn[i] * ONE);
		for (int i = 0; i < 9; i++)
			if ($urandom_range(0, 2) == 0)
				mat.m[i] = elem_t'(clamp_elem(mat.m[i]) +
					int'($urandom_range(0, 4000)) - 2000);
		return mat;
	endfunction

	task automatic send_matrix(input matrix_t mat);
		start <= 1'b1;
		m00 <= mat.m[0]; m01 <= mat.m[1]; m02 <= mat.m[2];
		m10 <= mat.m[3]; m11 <= mat.m[4]; m12 <= mat.m[5];
		m20 <= mat.m[6]; m21 <= mat.m[7]; m22 <= mat.m[8];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_quats = {pending_quats, quat_of_matrix(mat)};
	endtask

	// Random gap before the next transaction; start drops only when a gap
	// is actually taken, so it is never lowered and raised in one step.
	task automatic sender_gap();
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
		if ($urandom_range(0, 4) == 0)
			gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Result checker: done is a one-cycle strobe that cannot be held off.
	always @(posedge clk) begin
		quat_t exp_q;
		if (arst_n && done) begin
			if (pending_quats.size() == 0) begin
				$error("quaternion with no matrix outstanding: x=%0d y=%0d z=%0d w=%0d",
					quat_x, quat_y, quat_z, quat_w);
				fail_count++;
			end else begin
				exp_q = pending_quats.pop_front();
				if (quat_x !== exp_q.x) begin
					$error("quat_x expected %0d actual %0d", exp_q.x, quat_x);
					fail_count++;
				end
				if (quat_y !== exp_q.y) begin
					$error("quat_y expected %0d actual %0d", exp_q.y, quat_y);
					fail_count++;
				end
				if (quat_z !== exp_q.z) begin
					$error("quat_z expected %0d actual %0d", exp_q.z, quat_z);
					fail_count++;
				end
				if (quat_w !== exp_q.w) begin
					$error("quat_w expected %0d actual %0d", exp_q.w, quat_w);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		row_t  rows [$];
		row_t  row;
		quat_t got;
		int    drain;
		fail_count  = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		start  = 1'b0;
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;

		// Directed rows. The identity and the half turns about each axis have
		// quaternions that are plain to see; the rest go through the predictor.
		row.has_known = 1'b1;
		row.mat = make_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
		row.known = make_quat(0, 0, 0, ONE);
		rows = {rows, row};
		row.mat = make_matrix(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE);
		row.known = make_quat(ONE, 0, 0, 0);
		rows = {rows, row};
		row.mat = make_matrix(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE);
		row.known = make_quat(0, ONE, 0, 0);
		rows = {rows, row};
		row.mat = make_matrix(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE);
		row.known = make_quat(0, 0, ONE, 0);
		rows = {rows, row};
		// Inputs beyond one saturate, so this is the identity again.
		row.mat = make_matrix(32767, 0, 0, 0, 20000, 0, 0, 0, 16385);
		row.known = make_quat(0, 0, 0, ONE);
		rows = {rows, row};
		row.has_known = 1'b0;
		// Quarter turns about each axis, both senses.
		row.mat = make_matrix(ONE, 0, 0, 0, 0, -ONE, 0, ONE, 0);  rows = {rows, row};
		row.mat = make_matrix(ONE, 0, 0, 0, 0, ONE, 0, -ONE, 0);  rows = {rows, row};
		row.mat = make_matrix(0, 0, ONE, 0, ONE, 0, -ONE, 0, 0);  rows = {rows, row};
		row.mat = make_matrix(0, 0, -ONE, 0, ONE, 0, ONE, 0, 0);  rows = {rows, row};
		row.mat = make_matrix(0, -ONE, 0, ONE, 0, 0, 0, 0, ONE);  rows = {rows, row};
		row.mat = make_matrix(0, ONE, 0, -ONE, 0, 0, 0, 0, ONE);  rows = {rows, row};
		// Ties between lanes and zero off-diagonal sums.
		row.mat = make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0);         rows = {rows, row};
		row.mat = make_matrix(-ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE);
		rows = {rows, row};
		row.mat = make_matrix(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
		rows = {rows, row};
		// Most negative raw value and the bit patterns near it.
		row.mat = make_matrix(-32768, -32768, -32768, 32767, -32768, 32767, -32768,
			32767, -32768);
		rows = {rows, row};
		row.mat = make_matrix(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE); rows = {rows, row};
		row.mat = make_matrix(0, ONE, 0, ONE, 0, 0, 0, 0, -ONE);   rows = {rows, row};
		row.mat = make_matrix(0, 0, ONE, 0, -ONE, 0, ONE, 0, 0);   rows = {rows, row};
		row.mat = make_matrix(-ONE, 0, 0, 0, 0, ONE, 0, ONE, 0);   rows = {rows, row};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_matrix(rows[i].mat);
			if (rows[i].has_known) begin
				// Hand-typed values must agree with the predictor itself.
				got = pending_quats[$];
				if (got !== rows[i].known) begin
					$error("directed row %0d: predictor %0d %0d %0d %0d, typed %0d %0d %0d %0d",
						i, got.x, got.y, got.z, got.w, rows[i].known.x,
						rows[i].known.y, rows[i].known.z, rows[i].known.w);
					fail_count++;
				end
			end
			sender_gap();
		end

		// Hold off until the pipeline has drained completely.
		start <= 1'b0;
		while (pending_quats.size() != 0)
			@(posedge clk);

		for (int n = 0; n < N_RANDOM; n++) begin
			matrix_t mat;
			if ($urandom_range(0, 3) != 0) begin
				mat = rand_rotation();
			end else begin
				for (int i = 0; i < 9; i++)
					mat.m[i] = rand_elem();
			end
			send_matrix(mat);
			// Bursts with no gaps alternate with gappy stretches.
			if ((n / 100) % 3 != 0)
				sender_gap();
		end
		start <= 1'b0;

		drain = 0;
		while (pending_quats.size() != 0 && drain < 20 * LATENCY) begin
			@(posedge clk);
			drain++;
		end
		repeat (LATENCY + 10) @(posedge clk);

		if (fail_count == 0 && pending_quats.size() == 0) begin
			$display("end of test: clean");
		end else begin
			if (pending_quats.size() != 0)
				$error("%0d quaternions never arrived", pending_quats.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/rmq_pkg.sv
hdl/rmq_front.sv
hdl/rmq_sqrt_cell.sv
hdl/rmq_norm.sv
hdl/rmq_div_cell.sv
hdl/rotation_matrix_to_quaternion.sv
bench/rotation_matrix_to_quaternion_tb.sv
